### hdl/bac_pkg.sv
package bac_pkg;

    // species counts, each limited to the table depth
    localparam int NUM_PRIMARY   = 7;
    localparam int NUM_SECONDARY = 11;
    localparam int TBL_DEPTH     = 16;
    localparam int NP    = (NUM_PRIMARY > TBL_DEPTH) ? TBL_DEPTH : NUM_PRIMARY;
    localparam int NS    = (NUM_SECONDARY > TBL_DEPTH) ? TBL_DEPTH : NUM_SECONDARY;
    localparam int TOTAL = NP + NS;

    localparam int KW     = 5;   // species index width
    localparam int IW     = 32;  // ionic strength width
    localparam int RW     = 30;  // square root width
    localparam int CW     = 16;  // coefficient register width
    localparam int DVD_W  = 64;  // divider dividend width
    localparam int DVS_W  = 36;  // divider divisor width
    localparam int QDEPTH = 4;   // job queue depth
    localparam int QAW    = $clog2(QDEPTH);  // job queue pointer width

    typedef logic signed [2:0] t_charge;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DH_A = 2'd0,
        REG_DH_B = 2'd1,
        REG_BDOT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQRT,
        F_EMIT
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_MUL2,
        B_TGO,
        B_TWAIT,
        B_WGO,
        B_WWAIT,
        B_UGO,
        B_UWAIT,
        B_OUT
    } t_bstate;

    // one species job handed from front to back
    typedef struct packed {
        logic [IW-1:0] ion;
        logic [RW-1:0] root;
        logic [KW-1:0] k;
        logic          sec;
        t_charge       charge;
        logic [7:0]    size;
        logic          last;
    } t_job;

    typedef struct packed {
        logic              go;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quot;
    } t_div_rsp;

    typedef struct packed {
        logic [CW-1:0] dh_a;
        logic [CW-1:0] dh_b;
        logic [CW-1:0] bdot;
    } t_coef;

    function automatic t_charge prim_charge(input logic [3:0] i);
        case (i)
            4'd0:    return 3'sd1;
            4'd1:    return -3'sd1;
            4'd2:    return 3'sd2;
            4'd3:    return -3'sd2;
            4'd4:    return -3'sd1;
            4'd5:    return 3'sd2;
            4'd6:    return 3'sd1;
            default: return 3'sd0;
        endcase
    endfunction

    function automatic logic [7:0] prim_size(input logic [3:0] i);
        case (i)
            4'd0:    return 8'd144;
            4'd1:    return 8'd64;
            4'd2:    return 8'd96;
            4'd3:    return 8'd64;
            4'd4:    return 8'd48;
            4'd5:    return 8'd128;
            4'd6:    return 8'd64;
            default: return 8'd0;
        endcase
    endfunction

    function automatic t_charge sec_charge(input logic [3:0] i);
        case (i)
            4'd0:    return -3'sd1;
            4'd2:    return -3'sd2;
            4'd4:    return 3'sd1;
            4'd7:    return 3'sd1;
            4'd10:   return -3'sd1;
            default: return 3'sd0;
        endcase
    endfunction

    function automatic logic [7:0] sec_size(input logic [3:0] i);
        case (i)
            4'd0:    return 8'd56;
            4'd1:    return 8'd48;
            4'd2:    return 8'd72;
            4'd3:    return 8'd48;
            4'd4:    return 8'd64;
            4'd5:    return 8'd48;
            4'd6:    return 8'd48;
            4'd7:    return 8'd64;
            4'd8:    return 8'd48;
            4'd9:    return 8'd48;
            4'd10:   return 8'd64;
            default: return 8'd0;
        endcase
    endfunction

endpackage

### hdl/bac_ifs.sv
interface bac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] ionic_strength;
    modport source (output valid, output ionic_strength, input ready);
    modport sink   (input valid, input ionic_strength, output ready);
endinterface

interface bac_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         species_index;
    logic               is_secondary;
    logic signed [31:0] log_coeff;
    logic signed [31:0] d_log_coeff;
    logic               saturated;
    logic               last;
    modport source (output valid, output species_index, output is_secondary,
                    output log_coeff, output d_log_coeff, output saturated,
                    output last, input ready);
    modport sink   (input valid, input species_index, input is_secondary,
                    input log_coeff, input d_log_coeff, input saturated,
                    input last, output ready);
endinterface

interface bac_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bac_front.sv
module bac_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_ion,
    output logic          o_ready,
    output logic          o_push,
    output bac_pkg::t_job o_job,
    input  logic          i_full
);
    import bac_pkg::*;

    t_fstate           r_state, n_state;
    logic [IW-1:0]     r_ion;
    logic [59:0]       r_rad;
    logic [31:0]       r_rem;
    logic [RW-1:0]     r_root;
    logic [4:0]        r_cnt;
    logic [KW-1:0]     r_k;
    logic [33:0]       cur, trial;
    logic              take;
    logic              k_last;

    assign take   = i_valid && o_ready;
    assign k_last = (r_k == KW'(TOTAL - 1));

    // one root bit per cycle
    assign cur   = {r_rem, r_rad[59:58]};
    assign trial = {2'b00, r_root, 2'b01};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (take) n_state = F_SQRT;
            F_SQRT:  if (r_cnt == 5'd0) n_state = F_EMIT;
            F_EMIT:  if (!i_full && k_last) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_EMIT) && !i_full;
    end

    // job contents
    always_comb begin
        o_job.ion  = r_ion;
        o_job.root = r_root;
        o_job.k    = r_k;
        o_job.last = k_last;
        if (r_k < KW'(NP)) begin
            o_job.sec    = 1'b0;
            o_job.charge = prim_charge(r_k[3:0]);
            o_job.size   = prim_size(r_k[3:0]);
        end else begin
            o_job.sec    = 1'b1;
            o_job.charge = sec_charge(4'(r_k - KW'(NP)));
            o_job.size   = sec_size(4'(r_k - KW'(NP)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ion  <= i_ion;
            r_rad  <= {i_ion, 28'd0};
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 5'(RW - 1);
            r_k    <= '0;
        end else if (r_state == F_SQRT) begin
            r_rad <= {r_rad[57:0], 2'b00};
            r_cnt <= r_cnt - 5'd1;
            if (cur >= trial) begin
                r_rem  <= 32'(cur - trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= cur[31:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end else if (o_push) begin
            r_k <= r_k + KW'(1);
        end
    end

endmodule

### hdl/bac_fifo.sv
module bac_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bac_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output bac_pkg::t_job o_job
);
    import bac_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp, r_rp;
    logic [QAW:0]    r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QAW'(1);
            if (i_pop)  r_rp <= r_rp + QAW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/bac_div.sv
module bac_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bac_pkg::t_div_req i_req,
    output bac_pkg::t_div_rsp o_rsp
);
    import bac_pkg::*;

    logic              r_busy, r_done;
    logic [5:0]        r_cnt;
    logic [DVS_W-1:0]  r_rem, r_dvs;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W:0]    trial;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[DVD_W-1]};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd0);
            if (i_req.go) r_busy <= 1'b1;
            else if (r_cnt == 6'd0) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
            r_cnt <= 6'(DVD_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= DVS_W'(trial - {1'b0, r_dvs});
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

endmodule

### hdl/bac_back.sv
module bac_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bac_pkg::t_coef i_coef,
    input  logic           i_empty,
    input  bac_pkg::t_job  i_job,
    output logic           o_pop,
    bac_out_if.source      o_out
);
    import bac_pkg::*;

    t_bstate         r_state, n_state;
    t_job            r_job;
    logic [20:0]     r_num;
    logic [23:0]     r_ab;
    logic [28:0]     r_bi;
    logic [35:0]     r_dd;
    logic [50:0]     r_ns;
    logic [31:0]     r_t;
    logic [39:0]     r_u;
    logic            r_wbig;
    logic [39:0]     r_w;
    logic            r_ovalid;
    logic [2:0]      mag;
    logic [4:0]      z2;
    logic [53:0]     abs_prod;
    logic [47:0]     bi_prod;
    t_div_req        dreq;
    t_div_rsp        drsp;
    logic            out_free;
    logic            load;
    logic            skip_d;
    logic signed [33:0] lg;
    logic signed [41:0] dv;
    logic signed [31:0] lg_c, dv_c;
    logic            sat_l, sat_d;

    bac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_rsp   (drsp)
    );

    assign mag      = r_job.charge[2] ? 3'(-r_job.charge) : r_job.charge;
    assign z2       = 5'(mag * mag);
    assign abs_prod = r_ab * r_job.root;
    assign bi_prod  = i_coef.bdot * r_job.ion;
    assign out_free = !r_ovalid || o_out.ready;
    assign skip_d   = (r_num == '0) || (r_job.root == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_empty) n_state = B_MUL;
            B_MUL:   n_state = B_MUL2;
            B_MUL2:  n_state = B_TGO;
            B_TGO:   n_state = B_TWAIT;
            B_TWAIT: if (drsp.done) n_state = skip_d ? B_OUT : B_WGO;
            B_WGO:   n_state = B_WWAIT;
            B_WWAIT: if (drsp.done) n_state = (drsp.quot[63:40] != '0) ? B_OUT : B_UGO;
            B_UGO:   n_state = B_UWAIT;
            B_UWAIT: if (drsp.done) n_state = B_OUT;
            B_OUT:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // divider requests and queue pop
    always_comb begin
        o_pop         = (r_state == B_IDLE) && !i_empty;
        load          = (r_state == B_OUT) && out_free;
        dreq.go       = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;
        case (r_state)
            B_TGO: begin
                dreq.go       = 1'b1;
                dreq.dividend = {4'd0, r_ns, 9'd0};
                dreq.divisor  = r_dd;
            end
            B_WGO: begin
                dreq.go       = 1'b1;
                dreq.dividend = {6'd0, r_num, 37'd0};
                dreq.divisor  = {5'd0, r_job.root, 1'b0};
            end
            B_UGO: begin
                dreq.go       = 1'b1;
                dreq.dividend = {r_w, 24'd0};
                dreq.divisor  = {4'd0, r_dd[35:4]};
            end
            default: begin
                dreq.go = 1'b0;
            end
        endcase
    end

    // final values and clipping
    always_comb begin
        lg    = $signed({5'd0, r_bi}) - $signed({2'd0, r_t});
        sat_l = 1'b0;
        lg_c  = lg[31:0];
        if (lg > 34'sh0_7FFF_FFFF) begin
            lg_c  = 32'sh7FFF_FFFF;
            sat_l = 1'b1;
        end else if (lg < -34'sh0_8000_0000) begin
            lg_c  = 32'sh8000_0000;
            sat_l = 1'b1;
        end
        dv    = $signed({17'd0, i_coef.bdot, 9'd0}) - $signed({2'd0, r_u});
        sat_d = 1'b0;
        dv_c  = dv[31:0];
        if (r_num == '0) begin
            dv_c = $signed({7'd0, i_coef.bdot, 9'd0});
        end else if (r_job.root == '0 || r_wbig) begin
            dv_c  = 32'sh8000_0000;
            sat_d = 1'b1;
        end else if (dv < -42'sh0_8000_0000) begin
            dv_c  = 32'sh8000_0000;
            sat_d = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    // per-species datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
            end
            B_MUL: begin
                r_num  <= i_coef.dh_a * z2;
                r_ab   <= r_job.size * i_coef.dh_b;
                r_bi   <= bi_prod[47:19];
                r_wbig <= 1'b0;
            end
            B_MUL2: begin
                r_dd <= 36'(1 << 28) + 36'(abs_prod[53:19]);
                r_ns <= r_num * r_job.root;
            end
            B_TWAIT: if (drsp.done) r_t <= drsp.quot[31:0];
            B_WWAIT: if (drsp.done) begin
                r_w    <= drsp.quot[39:0];
                r_wbig <= (drsp.quot[63:40] != '0);
            end
            B_UWAIT: if (drsp.done) r_u <= drsp.quot[39:0];
            default: r_t <= r_t;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_out.species_index <= r_job.k;
            o_out.is_secondary  <= r_job.sec;
            o_out.log_coeff     <= lg_c;
            o_out.d_log_coeff   <= dv_c;
            o_out.saturated     <= sat_l || sat_d;
            o_out.last          <= r_job.last;
        end
    end

    assign o_out.valid = r_ovalid;

endmodule

### hdl/bdot_activity_coefficients.sv
// Channel  Dir  Word
// i_cfg    in   index (0 A, 1 B, 2 Bdot), data[15:0]; always ready
// i_in     in   ionic_strength, unsigned Q4.28
// o_out    out  species_index, is_secondary, log_coeff, d_log_coeff, saturated, last
//
// Each input word first has its square root formed bit by bit, then yields one
// result per species; a species runs all three divisions (each: issue, 64
// quotient bits, done) in the full case, fewer when the charge is zero,
// the root is zero or the derivative term overflows.
// Front and back are joined by a 4-entry job queue; the front takes the next
// word once all jobs of the current one are queued. Output stalls hold the
// result register and back the queue up. Reset is synchronous, active low.
module bdot_activity_coefficients (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bac_cfg_if.sink  i_cfg,
    bac_in_if.sink   i_in,
    bac_out_if.source o_out
);
    import bac_pkg::*;

    t_coef  r_coef;
    t_job   push_job, head_job;
    logic   push, full, pop, empty;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.dh_a <= 16'd17908;
            r_coef.dh_b <= 16'd10964;
            r_coef.bdot <= 16'd1435;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DH_A: r_coef.dh_a <= i_cfg.data;
                REG_DH_B: r_coef.dh_b <= i_cfg.data;
                REG_BDOT: r_coef.bdot <= i_cfg.data;
                default:  r_coef <= r_coef;
            endcase
        end
    end

    bac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_ion   (i_in.ionic_strength),
        .o_ready (i_in.ready),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    bac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    bac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### test/bdot_activity_coefficients_tb.sv
module bdot_activity_coefficients_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bac_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd8_000_000;
    localparam int DRAIN_CYCLES = 400;

    // one expected or observed species result
    typedef struct {
        logic [4:0]         species_index;
        logic               is_secondary;
        logic signed [31:0] log_coeff;
        logic signed [31:0] d_log_coeff;
        logic               saturated;
        logic               last;
    } t_species_res;

    class activity_scoreboard;
        logic [15:0] coef_a;
        logic [15:0] coef_b;
        logic [15:0] coef_bdot;
        t_species_res expected_q[$];
        int errors;
        int prim_z[16];
        int prim_a[16];
        int sec_z[16];
        int sec_a[16];

        function new();
            prim_z = '{1, -1, 2, -2, -1, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            prim_a = '{144, 64, 96, 64, 48, 128, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            sec_z  = '{-1, 0, -2, 0, 1, 0, 0, 1, 0, 0, -1, 0, 0, 0, 0, 0};
            sec_a  = '{56, 48, 72, 48, 64, 48, 48, 64, 48, 48, 64, 0, 0, 0, 0, 0};
            coef_a = 16'd17908;
            coef_b = 16'd10964;
            coef_bdot = 16'd1435;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] val);
            case (idx)
                REG_DH_A: coef_a = val;
                REG_DH_B: coef_b = val;
                REG_BDOT: coef_bdot = val;
                default: ;
            endcase
        endfunction

        // floor square root, bit by bit
        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // clip to signed 32 bits
        function logic signed [31:0] clip(logic signed [63:0] v, inout logic sat);
            if (v > 64'sd2147483647) begin
                sat = 1'b1;
                return 32'sh7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        // accepted ionic strength word: queue one result per species
        function void note_input(logic [31:0] ion);
            logic [63:0] iraw, root, z2, num, ab, dd, bi, t, w, u;
            logic signed [63:0] lg, dv;
            t_species_res r;
            int z, sz, idx;
            logic sec;
            iraw = {32'd0, ion};
            root = floor_sqrt(iraw << 28);
            for (int k = 0; k < TOTAL; k++) begin
                sec = (k >= NP);
                idx = sec ? k - NP : k;
                z = sec ? sec_z[idx] : prim_z[idx];
                sz = sec ? sec_a[idx] : prim_a[idx];
                z2 = z * z;
                num = coef_a * z2;
                ab = sz * coef_b;
                dd = (64'd1 << 28) + ((ab * root) >> 19);
                bi = (coef_bdot * iraw) >> 19;
                t = ((num * root) << 9) / dd;
                r.saturated = 1'b0;
                lg = $signed(bi) - $signed(t);
                r.log_coeff = clip(lg, r.saturated);
                if (num == 0) begin
                    r.d_log_coeff = {7'd0, coef_bdot, 9'd0};
                end else if (root == 0) begin
                    r.d_log_coeff = 32'sh80000000;
                    r.saturated = 1'b1;
                end else begin
                    w = (num << 37) / (2 * root);
                    if (w >= (64'd1 << 40)) begin
                        r.d_log_coeff = 32'sh80000000;
                        r.saturated = 1'b1;
                    end else begin
                        u = (w << 24) / (dd >> 4);
                        dv = $signed({39'd0, coef_bdot, 9'd0}) - $signed(u);
                        r.d_log_coeff = clip(dv, r.saturated);
                    end
                end
                r.species_index = k[4:0];
                r.is_secondary = sec;
                r.last = (k == TOTAL - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(t_species_res got);
            t_species_res exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word, species %0d", got.species_index);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.species_index !== exp_r.species_index ||
                got.is_secondary !== exp_r.is_secondary ||
                got.log_coeff !== exp_r.log_coeff ||
                got.d_log_coeff !== exp_r.d_log_coeff ||
                got.saturated !== exp_r.saturated ||
                got.last !== exp_r.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp k=%0d sec=%0b log=%0d d=%0d sat=%0b last=%0b",
                             exp_r.species_index, exp_r.is_secondary, exp_r.log_coeff,
                             exp_r.d_log_coeff, exp_r.saturated, exp_r.last);
                    $display("          got k=%0d sec=%0b log=%0d d=%0d sat=%0b last=%0b",
                             got.species_index, got.is_secondary, got.log_coeff,
                             got.d_log_coeff, got.saturated, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    longint cycles;
    bit no_idle;
    bit hold_req;
    activity_scoreboard sb;

    bac_cfg_if cfg_if();
    bac_in_if  in_if();
    bac_out_if out_if();

    bdot_activity_coefficients u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result sink: check, then pick ready for the next cycle
    initial begin
        int idle_left;
        int hold_left;
        t_species_res got;
        idle_left = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.species_index = out_if.species_index;
                got.is_secondary = out_if.is_secondary;
                got.log_coeff = out_if.log_coeff;
                got.d_log_coeff = out_if.d_log_coeff;
                got.saturated = out_if.saturated;
                got.last = out_if.last;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 6000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                out_if.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                idle_left = $urandom_range(1, 11) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // valid stays high; the caller drops it after the last write
    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, val);
    endtask

    task automatic send_word(logic [31:0] ion);
        int gap;
        in_if.valid <= 1'b1;
        in_if.ionic_strength <= ion;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(ion);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_if.valid <= 1'b0;
            in_if.ionic_strength <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_input();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every expected word, then let the block settle
    task automatic drain();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random ionic strength spread over all magnitudes
    function automatic logic [31:0] rand_ion();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 255);
            default: return $urandom_range(32'h0100_0000, 32'h3000_0000);
        endcase
    endfunction

    task automatic config_phase(logic [15:0] a, logic [15:0] b, logic [15:0] bd);
        write_reg(REG_DH_A, a);
        write_reg(REG_DH_B, b);
        write_reg(REG_BDOT, bd);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] directed[$];
        sb = new();
        no_idle = 1'b0;
        hold_req = 1'b0;
        i_rst_n <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_DH_A;
        cfg_if.data <= '0;
        in_if.valid <= 1'b0;
        in_if.ionic_strength <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, tiny values (huge derivative), unity, extremes
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd255, 32'h0000_4000,
                     32'h1000_0000, 32'h0800_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF};
        foreach (directed[i]) send_word(directed[i]);
        end_input();
        drain();

        // all coefficients at their maximum, with a long output stall
        config_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);
        hold_req = 1'b1;
        send_word(32'd0);
        send_word(32'd1);
        send_word(32'hFFFF_FFFF);
        repeat (95) send_word(rand_ion());
        end_input();
        drain();

        // all coefficients zero
        config_phase(16'h0000, 16'h0000, 16'h0000);
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        repeat (98) send_word(rand_ion());
        end_input();
        drain();

        // random coefficients
        config_phase(16'($urandom), 16'($urandom), 16'($urandom));
        repeat (100) send_word(rand_ion());
        end_input();
        drain();

        // back to typical values, no idling on either side
        config_phase(16'd17908, 16'd10964, 16'd1435);
        no_idle = 1'b1;
        repeat (100) send_word(rand_ion());
        end_input();
        drain();

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### bdot_activity_coefficients.f
hdl/bac_pkg.sv
hdl/bac_ifs.sv
hdl/bac_front.sv
hdl/bac_fifo.sv
hdl/bac_div.sv
hdl/bac_back.sv
hdl/bdot_activity_coefficients.sv
test/bdot_activity_coefficients_tb.sv
